>>> design/lrukv_pkg.sv
`default_nettype none

package lrukv_pkg;

  // Width of the capacity register and its value after reset.
  localparam int unsigned CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Largest value of the saturating miss counter.
  localparam logic [31:0] MISS_MAX = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] key;
    logic signed [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
    logic        [31:0] miss_total;
  } rsp_t;

endpackage

`default_nettype wire

>>> design/lru_cache_key_value_store.sv
`default_nettype none

// Channel   Direction  Handshake                 Word
// --------  ---------  ------------------------  ---------------------------------
// in        input      in_valid_i / in_stall_o   in_word_i  (operation, key, value)
// out       output     out_valid_o / out_stall_i out_word_o (hit, data, eviction)
// cfg       input      cfg_we_i                  cfg_wdata_i (capacity_in_use)
//
// One word is accepted per cycle when nothing stalls; its result reaches the
// output as the word moves from the input register into the result register.
// The lookup, the recency update and the miss count for a word are done together
// by the parallel key compare and rank update over all entries.
// Reset clears the valid bits, the occupancy, the miss counter and sets the
// capacity to 64; keys, values and ranks are not cleared and there is no clearing
// pass, so the block accepts words right after reset.
// A stall at the output holds the result register and, when the input register
// is also full, raises in_stall_o in the same cycle.

module lru_cache_key_value_store
  import lrukv_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire req_t             in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output rsp_t                  out_word_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i
);

  // Slot index and recency rank need enough bits to name every entry; the
  // occupancy also has to hold the full count.
  localparam int unsigned IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned OccW  = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW  = (OccW > CAP_W) ? OccW : CAP_W;

  // Input register.
  logic in_valid_q;
  req_t in_q;

  // Result register. The read data comes straight from the value memory's
  // registered read port and is masked unless the word was a read hit.
  logic        out_valid_q;
  rsp_t        res_q;
  logic        rd_sel_q;
  logic [31:0] rd_data_q;

  // Cache state. Keys, ranks and valid bits are flip-flops so that every entry
  // can be compared and aged in parallel.
  logic [31:0]      key_q   [ENTRIES];
  logic [RankW-1:0] rank_q  [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [31:0]      val_mem [ENTRIES];
  logic [OccW-1:0]  occ_q;
  logic [31:0]      miss_q;
  logic [CAP_W-1:0] cap_q;

  logic               advance;
  logic               is_write;
  logic [ENTRIES-1:0] match_oh;
  logic [ENTRIES-1:0] victim_oh;
  logic [ENTRIES-1:0] free_oh;
  logic [ENTRIES-1:0] slot_oh;
  logic [ENTRIES-1:0] inv_vec;
  logic [ENTRIES-1:0] age_vec;
  logic [IdxW-1:0]    hit_idx;
  logic [IdxW-1:0]    slot_idx;
  logic [RankW-1:0]   hit_rank;
  logic [RankW-1:0]   last_rank;
  logic [31:0]        victim_key;
  logic               hit;
  logic               full;
  logic               evict;
  logic               insert;
  logic [CmpW-1:0]    eff_cap;
  logic [OccW-1:0]    occ_d;
  logic [31:0]        miss_d;
  rsp_t               res_d;

  // The word in the input register moves on when the result register is free
  // or is being emptied in this cycle.
  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign is_write   = (in_q.operation == OP_WRITE);

  // A register value of zero acts as one, and values above the entry count act
  // as the entry count.
  always_comb begin
    eff_cap = CmpW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CmpW'(1);
    end else if (eff_cap > CmpW'(ENTRIES)) begin
      eff_cap = CmpW'(ENTRIES);
    end
  end

  assign full      = CmpW'(occ_q) >= eff_cap;
  assign last_rank = RankW'(occ_q - 1'b1);
  assign inv_vec   = ~valid_q;
  // Lowest-numbered free slot, isolated as the lowest set bit.
  assign free_oh   = inv_vec & (~inv_vec + 1'b1);

  // Parallel tag compare. Valid keys are distinct, so at most one entry matches.
  // The least recent entry is the valid one whose rank is occupancy minus one.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_oh[i]  = valid_q[i] && (key_q[i] == in_q.key);
      victim_oh[i] = valid_q[i] && (rank_q[i] == last_rank);
    end
  end

  assign hit    = |match_oh;
  assign evict  = is_write && !hit && full;
  assign insert = is_write && !hit && !full;

  always_comb begin
    hit_rank   = '0;
    victim_key = '0;
    hit_idx    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_oh[i]) begin
        hit_rank = hit_rank | rank_q[i];
        hit_idx  = hit_idx | IdxW'(i);
      end
      if (victim_oh[i] && evict) begin
        victim_key = victim_key | key_q[i];
      end
    end
  end

  // Slot touched by this word: the hit entry, the victim, or the free slot.
  always_comb begin
    priority if (hit) begin
      slot_oh = match_oh;
    end else if (full) begin
      slot_oh = victim_oh;
    end else begin
      slot_oh = free_oh;
    end
    slot_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_oh[i]) begin
        slot_idx = slot_idx | IdxW'(i);
      end
    end
  end

  // Making a slot most recent ages every valid entry that was more recent than
  // it. On a write miss that is every other valid entry.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      age_vec[i] = valid_q[i] && !slot_oh[i] &&
                   ((hit && (rank_q[i] < hit_rank)) || (is_write && !hit));
    end
  end

  assign occ_d  = insert ? occ_q + 1'b1 : occ_q;
  assign miss_d = (!hit && (miss_q != MISS_MAX)) ? miss_q + 1'b1 : miss_q;

  always_comb begin
    res_d             = '0;
    res_d.hit         = hit;
    res_d.evicted     = evict;
    res_d.evicted_key = victim_key;
    res_d.miss_total  = miss_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      miss_q      <= '0;
      cap_q       <= CAP_RESET;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        occ_q       <= occ_d;
        miss_q      <= miss_d;
        if (insert) begin
          valid_q <= valid_q | slot_oh;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers and per-entry key and rank storage.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      res_q    <= res_d;
      rd_sel_q <= hit && !is_write;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_oh[i] && (hit || is_write)) begin
          rank_q[i] <= '0;
        end else if (age_vec[i]) begin
          rank_q[i] <= rank_q[i] + 1'b1;
        end
        if (slot_oh[i] && is_write && !hit) begin
          key_q[i] <= in_q.key;
        end
      end
    end
  end

  // Value memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rd_data_q <= val_mem[hit_idx];
      if (is_write) begin
        val_mem[slot_idx] <= in_q.write_value;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    out_word_o            = res_q;
    out_word_o.read_value = rd_sel_q ? rd_data_q : '0;
  end

`ifndef NO_ASSERTIONS
  // Keys of valid entries stay distinct, so a lookup never matches twice.
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> $onehot0(match_oh))
    else $error("more than one entry matches the key");

  // The fill count follows the valid bits.
  a_occ_tracks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == occ_q)
    else $error("occupancy differs from the number of valid entries");

  // An eviction always finds exactly one least recent entry.
  a_victim_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && evict) |-> $onehot(victim_oh))
    else $error("no unique least recent entry on eviction");

  // An insert without eviction grows the occupancy by one.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && insert) |=> (occ_q == $past(occ_q) + 1'b1))
    else $error("insert did not grow the occupancy");
`endif

endmodule

`default_nettype wire
